/* rtl/core/imgdiff_pkg.sv */
// shared types and constants for the image diff checker with exempt-range table
`timescale 1ns / 1ps
`default_nettype none

package imgdiff_pkg;

  localparam int TableDepth  = 256;
  localparam int OffsetW     = 32;
  localparam int EntryIdxW   = 8;
  localparam int LenW        = 7;
  localparam int CountW      = 32;
  localparam int EntryCountW = 9;
  localparam int FuncW       = 2;
  localparam int CfgIdxW     = 1;

  localparam logic [FuncW-1:0] FuncLoad    = 2'd0;
  localparam logic [FuncW-1:0] FuncCompare = 2'd1;
  localparam logic [FuncW-1:0] FuncFinish  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgEntryCount = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDiffLimit  = 1'd1;

  localparam logic [CountW-1:0] DiffLimitRst = 32'd64;
  localparam logic [CountW-1:0] CountMax     = '1;

  // item as it travels down the cell row
  typedef struct packed {
    logic [FuncW-1:0]     func;
    logic [EntryIdxW-1:0] idx;
    logic [OffsetW-1:0]   addr;  // entry start on load, byte offset on compare
    logic [LenW-1:0]      len;
    logic                 diff;  // reference and live byte differ
    logic                 hit;   // offset found in an exempt range so far
  } item_t;

endpackage

`default_nettype wire

/* rtl/core/imgdiff_cell.sv */
// one cell of the row: holds one exempt range and checks the passing item
`timescale 1ns / 1ps
`default_nettype none

module imgdiff_cell (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 adv_i,
  input  wire logic [imgdiff_pkg::EntryIdxW-1:0]    cell_idx_i,
  input  wire logic [imgdiff_pkg::EntryCountW-1:0]  entry_count_i,
  input  wire logic                                 valid_i,
  input  wire imgdiff_pkg::item_t                   item_i,
  output logic                                      valid_o,
  output imgdiff_pkg::item_t                        item_o
);

  logic [imgdiff_pkg::OffsetW-1:0] start_q;
  logic [imgdiff_pkg::LenW-1:0]    len_q;
  logic                            valid_q;
  imgdiff_pkg::item_t              item_q;
  imgdiff_pkg::item_t              item_d;

  logic                            active;
  logic                            above;
  logic [imgdiff_pkg::OffsetW-1:0] gap;
  logic                            in_range;
  logic                            wr_en;

  assign active   = {1'b0, cell_idx_i} < entry_count_i;
  assign above    = item_i.addr >= start_q;
  assign gap      = item_i.addr - start_q;
  assign in_range = above &&
                    (gap < {{(imgdiff_pkg::OffsetW-imgdiff_pkg::LenW){1'b0}}, len_q});

  assign wr_en = adv_i && valid_i && (item_i.func == imgdiff_pkg::FuncLoad) &&
                 (item_i.idx == cell_idx_i);

  always_comb begin
    item_d     = item_i;
    item_d.hit = item_i.hit ||
                 ((item_i.func == imgdiff_pkg::FuncCompare) && active && in_range);
  end

  // table entry, undefined until loaded
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_q <= item_i.addr;
      len_q   <= item_i.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* rtl/core/imgdiff_tally.sv */
// end of the row: difference counter, finish check and output register
`timescale 1ns / 1ps
`default_nettype none

module imgdiff_tally (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [imgdiff_pkg::CountW-1:0]  diff_limit_i,
  input  wire logic                            valid_i,
  input  wire imgdiff_pkg::item_t              item_i,
  input  wire logic                            out_ready_i,
  output logic                                 adv_o,
  output logic                                 out_valid_o,
  output logic                                 mismatch_o,
  output logic                                 exempted_o,
  output logic [imgdiff_pkg::CountW-1:0]       diff_total_o,
  output logic                                 alarm_o
);

  logic [imgdiff_pkg::CountW-1:0] count_q, count_d;
  logic                           out_valid_q;
  logic                           mismatch_q, mismatch_d;
  logic                           exempted_q, exempted_d;
  logic [imgdiff_pkg::CountW-1:0] total_q, total_d;
  logic                           alarm_q, alarm_d;
  logic                           adv;

  // whole row moves when the output register is free or being drained
  assign adv = !out_valid_q || out_ready_i;

  always_comb begin
    count_d    = count_q;
    mismatch_d = 1'b0;
    exempted_d = 1'b0;
    alarm_d    = 1'b0;
    total_d    = count_q;
    case (item_i.func)
      imgdiff_pkg::FuncCompare: begin
        if (item_i.diff) begin
          if (item_i.hit) begin
            exempted_d = 1'b1;
          end else begin
            mismatch_d = 1'b1;
            if (count_q != imgdiff_pkg::CountMax) begin
              count_d = count_q + 1'b1;
            end
          end
        end
        total_d = count_d;
      end
      imgdiff_pkg::FuncFinish: begin
        alarm_d = count_q > diff_limit_i;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_i;
      if (valid_i) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      mismatch_q <= mismatch_d;
      exempted_q <= exempted_d;
      total_q    <= total_d;
      alarm_q    <= alarm_d;
    end
  end

  assign adv_o        = adv;
  assign out_valid_o  = out_valid_q;
  assign mismatch_o   = mismatch_q;
  assign exempted_o   = exempted_q;
  assign diff_total_o = total_q;
  assign alarm_o      = alarm_q;

endmodule

`default_nettype wire

/* rtl/core/image_diff_with_range_whitelist.sv */
// path: an accepted item reaches the output register after passing TableDepth range
// cells and then the tally register
// throughput: one item per cycle; every item walks the row one cell a cycle and the
// whole row stalls only while a result waits at the output
// reset: clears the difference count, entry_count to 0 and diff_limit to 64;
// range entries hold no reset value and are undefined until loaded
`timescale 1ns / 1ps
`default_nettype none

module image_diff_with_range_whitelist (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [imgdiff_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [31:0]                        cfg_data_i,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // entry_index, entry_start, entry_length, byte_offset, reference_byte, live_byte, pad
  input  wire logic [95:0]                        s_axis_tdata_i,
  // func
  input  wire logic [1:0]                         s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // mismatch, exempted, diff_total, alarm, pad
  output logic [39:0]                             m_axis_tdata_o
);

  localparam int Depth = imgdiff_pkg::TableDepth;

  logic [imgdiff_pkg::EntryCountW-1:0] entry_count_q;
  logic [imgdiff_pkg::CountW-1:0]      diff_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      diff_limit_q  <= imgdiff_pkg::DiffLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        imgdiff_pkg::CfgEntryCount: entry_count_q <= cfg_data_i[imgdiff_pkg::EntryCountW-1:0];
        imgdiff_pkg::CfgDiffLimit:  diff_limit_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // unpack the input item
  logic [7:0]  in_idx;
  logic [31:0] in_start;
  logic [6:0]  in_len;
  logic [31:0] in_ofs;
  logic [7:0]  in_ref;
  logic [7:0]  in_live;

  assign in_idx   = s_axis_tdata_i[7:0];
  assign in_start = s_axis_tdata_i[39:8];
  assign in_len   = s_axis_tdata_i[46:40];
  assign in_ofs   = s_axis_tdata_i[78:47];
  assign in_ref   = s_axis_tdata_i[86:79];
  assign in_live  = s_axis_tdata_i[94:87];

  imgdiff_pkg::item_t head;

  always_comb begin
    head.func = s_axis_tuser_i;
    head.idx  = in_idx;
    head.addr = (s_axis_tuser_i == imgdiff_pkg::FuncLoad) ? in_start : in_ofs;
    head.len  = in_len;
    head.diff = in_ref != in_live;
    head.hit  = 1'b0;
  end

  logic                 adv;
  logic                 chain_valid [Depth+1];
  imgdiff_pkg::item_t   chain_item  [Depth+1];

  assign chain_valid[0] = s_axis_tvalid_i;
  assign chain_item[0]  = head;

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    imgdiff_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .adv_i         (adv),
      .cell_idx_i    (imgdiff_pkg::EntryIdxW'(k)),
      .entry_count_i (entry_count_q),
      .valid_i       (chain_valid[k]),
      .item_i        (chain_item[k]),
      .valid_o       (chain_valid[k+1]),
      .item_o        (chain_item[k+1])
    );
  end

  logic                           res_mismatch;
  logic                           res_exempted;
  logic [imgdiff_pkg::CountW-1:0] res_total;
  logic                           res_alarm;

  imgdiff_tally u_tally (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .diff_limit_i (diff_limit_q),
    .valid_i      (chain_valid[Depth]),
    .item_i       (chain_item[Depth]),
    .out_ready_i  (m_axis_tready_i),
    .adv_o        (adv),
    .out_valid_o  (m_axis_tvalid_o),
    .mismatch_o   (res_mismatch),
    .exempted_o   (res_exempted),
    .diff_total_o (res_total),
    .alarm_o      (res_alarm)
  );

  assign s_axis_tready_o = adv;
  assign m_axis_tdata_o  = {5'b0, res_alarm, res_total, res_exempted, res_mismatch};

endmodule

`default_nettype wire

/* dv/imgdiff_checker.sv */
// scoreboard for the image diff checker: predicts every result and compares it
`timescale 1ns / 1ps

module imgdiff_checker
  import imgdiff_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [95:0]        s_tdata_i,
  input  logic [1:0]         s_tuser_i,
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [39:0]        m_tdata_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 counted_o,
  output int                 exempt_o,
  output int                 alarm_o
);

  typedef struct packed {
    logic              mismatch;
    logic              exempted;
    logic [CountW-1:0] total;
    logic              alarm;
  } scan_result_t;

  logic [OffsetW-1:0]     rng_start [TableDepth];
  logic [LenW-1:0]        rng_len   [TableDepth];
  logic [CountW-1:0]      diff_cnt;
  logic [EntryCountW-1:0] n_entries;
  logic [CountW-1:0]      limit;
  scan_result_t           expected_q [$];

  int n_fail    = 0;
  int n_counted = 0;
  int n_exempt  = 0;
  int n_alarm   = 0;

  assign fail_count_o = n_fail;
  assign pending_o    = expected_q.size();
  assign counted_o    = n_counted;
  assign exempt_o     = n_exempt;
  assign alarm_o      = n_alarm;

  // range test without wrap: start <= ofs < start + len
  function automatic logic offset_exempt(input logic [OffsetW-1:0] ofs);
    int n;
    int k;
    n = (n_entries > TableDepth) ? TableDepth : int'(n_entries);
    for (k = 0; k < n; k++) begin
      if (ofs >= rng_start[k] && (ofs - rng_start[k]) < OffsetW'(rng_len[k])) return 1'b1;
    end
    return 1'b0;
  endfunction

  // fields from the low bit up: slot, start, len, offset, reference byte, live byte
  function automatic scan_result_t score_item(input logic [1:0] func, input logic [95:0] d);
    scan_result_t r;
    r = '0;
    r.total = diff_cnt;
    case (func)
      FuncLoad: begin
        rng_start[d[7:0]] = d[39:8];
        rng_len[d[7:0]]   = d[46:40];
      end
      FuncCompare: begin
        if (d[86:79] != d[94:87]) begin
          if (offset_exempt(d[78:47])) begin
            r.exempted = 1'b1;
            n_exempt++;
          end else begin
            r.mismatch = 1'b1;
            n_counted++;
            if (diff_cnt != CountMax) diff_cnt++;
          end
        end
        r.total = diff_cnt;
      end
      FuncFinish: begin
        r.alarm  = (diff_cnt > limit);
        r.total  = diff_cnt;
        diff_cnt = '0;
        if (r.alarm) n_alarm++;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_field(input string name, input logic [CountW-1:0] exp_v,
                              input logic [CountW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    scan_result_t want;
    if (!rst_ni) begin
      diff_cnt  = '0;
      n_entries = '0;
      limit     = DiffLimitRst;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgEntryCount) n_entries = cfg_data_i[EntryCountW-1:0];
        else if (cfg_idx_i == CfgDiffLimit) limit = cfg_data_i;
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no item pending, expected none actual %h",
                   $time, m_tdata_i);
          n_fail++;
        end else begin
          want = expected_q.pop_front();
          report_field("mismatch", CountW'(want.mismatch), CountW'(m_tdata_i[0]));
          report_field("exempted", CountW'(want.exempted), CountW'(m_tdata_i[1]));
          report_field("diff_total", want.total, m_tdata_i[33:2]);
          report_field("alarm", CountW'(want.alarm), CountW'(m_tdata_i[34]));
        end
      end
      if (s_tvalid_i && s_tready_i) expected_q.push_back(score_item(s_tuser_i, s_tdata_i));
    end
  end

endmodule

/* dv/tb_top.sv */
// testbench top for the image diff checker: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_top;
  import imgdiff_pkg::*;

  localparam logic [FuncW-1:0] FuncUnknown = 2'd3;
  localparam logic [OffsetW-1:0] ClusterBase = 32'h4000_0000;
  localparam int IdleLimit   = 4000;
  localparam int HoldCycles  = 700;
  localparam int DrainCycles = TableDepth + 40;
  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 165;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               cfg_we   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx  = '0;
  logic [31:0]        cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [95:0]        s_tdata  = '0;
  logic [1:0]         s_tuser  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [39:0]        m_tdata;

  int fail_count, pending, counted, exempted, alarms;
  int tx_idle_pct = 13;
  int rx_idle_pct = 71;
  bit hold_go     = 1'b0;
  int stall_cycles = 0;
  int cur_entries  = 0;
  int n_settings   = 0;
  int n_sent [4]   = '{default: 0};

  // stimulus-side copy of the table, used only to aim offsets at loaded ranges
  logic [OffsetW-1:0] tbl_start [TableDepth];

  image_diff_with_range_whitelist i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  imgdiff_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .counted_o    (counted),
    .exempt_o     (exempted),
    .alarm_o      (alarms)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: random backpressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        repeat (HoldCycles) begin
          m_tready <= 1'b0;
          @(negedge clk);
        end
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input logic [FuncW-1:0] func, input logic [EntryIdxW-1:0] slot,
                           input logic [OffsetW-1:0] start, input logic [LenW-1:0] len,
                           input logic [OffsetW-1:0] ofs, input logic [7:0] ref_b,
                           input logic [7:0] live_b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {1'b0, live_b, ref_b, ofs, len, start, slot};
    do @(posedge clk); while (!s_tready);
    n_sent[func]++;
    @(negedge clk);
  endtask

  task automatic load_range(input logic [EntryIdxW-1:0] slot, input logic [OffsetW-1:0] start,
                            input logic [LenW-1:0] len);
    tbl_start[slot] = start;
    send_item(FuncLoad, slot, start, len, $urandom, 8'($urandom), 8'($urandom));
  endtask

  task automatic compare_byte(input logic [OffsetW-1:0] ofs, input logic [7:0] ref_b,
                              input logic [7:0] live_b);
    send_item(FuncCompare, EntryIdxW'($urandom), $urandom, LenW'($urandom), ofs, ref_b,
              live_b);
  endtask

  task automatic finish_scan();
    send_item(FuncFinish, EntryIdxW'($urandom), $urandom, LenW'($urandom), $urandom,
              8'($urandom), 8'($urandom));
  endtask

  // stop offering and wait for every expected result
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input int entries, input logic [31:0] lim);
    write_reg(CfgEntryCount, 32'(entries));
    write_reg(CfgDiffLimit, lim);
    cur_entries = entries;
    n_settings++;
  endtask

  // most starts sit in one cluster so ranges overlap and offsets hit them
  function automatic logic [OffsetW-1:0] pick_start();
    if ($urandom_range(99) < 80) return ClusterBase + OffsetW'($urandom_range(16'h3FFF));
    return $urandom;
  endfunction

  function automatic logic [OffsetW-1:0] pick_offset();
    int k;
    if (cur_entries > 0 && $urandom_range(99) < 65) begin
      k = $urandom_range(cur_entries - 1);
      return tbl_start[k] - 32'd2 + OffsetW'($urandom_range(132));
    end
    if ($urandom_range(99) < 15) return 32'hFFFF_FF00 + OffsetW'($urandom_range(255));
    return $urandom;
  endfunction

  task automatic rand_item();
    int r;
    logic [7:0] rb;
    r  = $urandom_range(99);
    rb = 8'($urandom);
    if (r < 10) begin
      load_range(EntryIdxW'($urandom_range(TableDepth - 1)), pick_start(), LenW'($urandom));
    end else if (r < 80) begin
      compare_byte(pick_offset(), rb, ($urandom_range(99) < 30) ? rb : 8'($urandom));
    end else if (r < 95) begin
      finish_scan();
    end else begin
      send_item(FuncUnknown, EntryIdxW'($urandom), $urandom, LenW'($urandom), $urandom,
                8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int p;
    int i;
    int k;
    logic [31:0] lim;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // nothing searched yet: every differing byte counts
    compare_byte(32'h0, 8'h00, 8'h00);
    compare_byte(32'h0, 8'hFF, 8'h00);
    compare_byte(32'hFFFF_FFFF, 8'h00, 8'hFF);
    send_item(FuncUnknown, '1, '1, '1, '1, '1, '1);
    finish_scan();

    // fill every slot before any entry is searched
    load_range(8'd0, 32'hFFFF_FFF0, 7'd127);
    load_range(8'd1, 32'h0000_1000, 7'd0);
    load_range(8'd2, 32'h0000_0000, 7'd1);
    for (k = 3; k < TableDepth - 1; k++) begin
      load_range(EntryIdxW'(k), ClusterBase + $urandom_range(16'h3FFF), LenW'($urandom));
    end
    load_range(8'd255, 32'hFFFF_FFFF, 7'd127);
    drain();
    set_config(TableDepth, 32'd0);

    compare_byte(32'hFFFF_FFFF, 8'h01, 8'h02);  // top of offset space, exempt
    compare_byte(32'hFFFF_FFEF, 8'h01, 8'h02);  // one below a range
    compare_byte(32'h0, 8'h03, 8'h04);
    compare_byte(32'h1, 8'h03, 8'h04);
    compare_byte(32'h5, 8'h03, 8'h04);          // a range at the top must not wrap to zero
    compare_byte(32'h1000, 8'h07, 8'h08);       // zero-length range exempts nothing
    compare_byte(32'h1000, 8'h07, 8'h07);
    finish_scan();
    finish_scan();
    drain();
    set_config(1, 32'hFFFF_FFFF);
    compare_byte(32'h0, 8'h01, 8'h02);
    compare_byte(32'hFFFF_FFF5, 8'h01, 8'h02);
    finish_scan();
    drain();

    for (p = 0; p < NumPhases; p++) begin
      case (p)
        0: set_config(TableDepth, 32'd0);
        1: set_config(0, 32'hFFFF_FFFF);
        2: set_config(1, DiffLimitRst);
        default: begin
          lim = ($urandom_range(3) == 0) ? $urandom : $urandom_range(12);
          set_config($urandom_range(TableDepth), lim);
        end
      endcase
      if (p < 3) begin
        tx_idle_pct = 13;
        rx_idle_pct = 71;
      end else if (p < 6) begin
        tx_idle_pct = 71;
        rx_idle_pct = 13;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (i = 0; i < PhaseItems; i++) begin
        // long receiver hold-off while the sender keeps offering items
        if (p == 6 && i == 20) hold_go = 1'b1;
        rand_item();
      end
      drain();
    end

    repeat (DrainCycles) @(negedge clk);
    $display("covered %0d loads, %0d compares, %0d finishes, %0d unknown items, %0d settings",
             n_sent[FuncLoad], n_sent[FuncCompare], n_sent[FuncFinish], n_sent[FuncUnknown],
             n_settings);
    $display("predicted %0d counted differences, %0d exempt, %0d alarms",
             counted, exempted, alarms);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
